### src/wlp_pkg.sv
// ============================================================================
// wlp_pkg
// Shared types, constants and helpers for the weighted lane picker.
// ============================================================================
package wlp_pkg;

    // Lane table size and derived widths
    localparam int LANE_COUNT = 4;
    localparam int LANE_W     = 2;                              // chosen_index width
    localparam int CNT_W      = 3;                              // active_lanes width
    localparam int TOTAL_W    = 8 + $clog2(LANE_COUNT + 1);     // sum of all weights
    localparam int CREDIT_W   = 16;
    localparam int ALU_W      = CREDIT_W + 2;

    // Register reset values
    localparam logic [31:0]      WEIGHTS_RST = 32'h0101_0101;
    localparam logic [31:0]      IDS_RST     = 32'h0302_0100;
    localparam logic [CNT_W-1:0] ACTIVE_RST  = 3'd4;
    localparam logic [15:0]      LIMIT_RST   = 16'd8;

    // Register map, word index (paddr[3:2])
    typedef enum logic [1:0] {
        REG_WEIGHTS = 2'd0,
        REG_IDS     = 2'd1,
        REG_ACTIVE  = 2'd2,
        REG_LIMIT   = 2'd3
    } t_reg_idx;

    // Sequencer states
    typedef enum logic [2:0] {
        S_IDLE,
        S_ADD,
        S_PICK,
        S_FALL,
        S_UPD,
        S_OUT
    } t_state;

    typedef struct packed {
        logic [15:0] depth_lane0;
        logic [15:0] depth_lane1;
        logic [15:0] depth_lane2;
        logic [15:0] depth_lane3;
    } t_req;

    typedef struct packed {
        logic [7:0]        chosen_id;
        logic [LANE_W-1:0] chosen_index;
        logic              used_fallback;
        logic              no_lane;
    } t_rsp;

    // Clamp a widened sum back to the signed credit range
    function automatic logic signed [CREDIT_W-1:0] sat_credit(
        input logic signed [ALU_W-1:0] v
    );
        logic signed [ALU_W-1:0] hi;
        logic signed [ALU_W-1:0] lo;
        hi = ALU_W'(32767);
        lo = -ALU_W'(32768);
        if (v > hi) begin
            return 16'sh7FFF;
        end else if (v < lo) begin
            return 16'sh8000;
        end else begin
            return v[CREDIT_W-1:0];
        end
    endfunction

endpackage

### src/weighted_lane_picker_with_depth_gate.sv
// ============================================================================
// weighted_lane_picker_with_depth_gate
// Smooth weighted round-robin lane picker with a queue-depth gate.
// ============================================================================
// Flow: accept, raise each active credit (N = active lanes, up to 4), pick,
//   a fallback walk when every lane is at or over the depth limit, debit the
//   winner, load the result; with N=0 it goes straight to the result.
// One transaction at a time; the lane walk runs through the single credit adder
//   and comparator, and the result waits while the result register stalls.
// Reset: synchronous active-low; credits clear to zero, registers take their
//   defaults, sequencer returns to idle and the result register empties.
// ============================================================================
module weighted_lane_picker_with_depth_gate (
    input  logic                 i_clk,
    input  logic                 i_rst_n,

    // Request channel
    input  logic                 i_in_valid,
    output logic                 o_in_ready,
    input  wlp_pkg::t_req        i_in_data,

    // Result channel
    output logic                 o_out_valid,
    input  logic                 i_out_ready,
    output wlp_pkg::t_rsp        o_out_data,

    // APB-style configuration port
    input  logic                 psel,
    input  logic                 penable,
    input  logic                 pwrite,
    input  logic [3:0]           paddr,
    input  logic [31:0]          pwdata,
    output logic [31:0]          prdata,
    output logic                 pready
);

    // ------------------------------------------------------------------
    // Configuration registers
    // ------------------------------------------------------------------
    logic [31:0]                   r_weights;
    logic [31:0]                   r_ids;
    logic [wlp_pkg::CNT_W-1:0]     r_active;
    logic [15:0]                   r_limit;

    logic                          cfg_wr;
    wlp_pkg::t_reg_idx             cfg_idx;
    logic                          cred_clr;   // lane table rewritten

    assign pready   = 1'b1;
    assign cfg_wr   = psel & penable & pwrite;
    assign cfg_idx  = wlp_pkg::t_reg_idx'(paddr[3:2]);
    assign cred_clr = cfg_wr && (cfg_idx != wlp_pkg::REG_LIMIT);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_weights <= wlp_pkg::WEIGHTS_RST;
            r_ids     <= wlp_pkg::IDS_RST;
            r_active  <= wlp_pkg::ACTIVE_RST;
            r_limit   <= wlp_pkg::LIMIT_RST;
        end else if (cfg_wr) begin
            unique case (cfg_idx)
                wlp_pkg::REG_WEIGHTS: r_weights <= pwdata;
                wlp_pkg::REG_IDS:     r_ids     <= pwdata;
                wlp_pkg::REG_ACTIVE:  r_active  <= pwdata[wlp_pkg::CNT_W-1:0];
                wlp_pkg::REG_LIMIT:   r_limit   <= pwdata[15:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        unique case (cfg_idx)
            wlp_pkg::REG_WEIGHTS: prdata = r_weights;
            wlp_pkg::REG_IDS:     prdata = r_ids;
            wlp_pkg::REG_ACTIVE:  prdata = {{(32-wlp_pkg::CNT_W){1'b0}}, r_active};
            wlp_pkg::REG_LIMIT:   prdata = {16'h0000, r_limit};
            default:              prdata = '0;
        endcase
    end

    // Effective lane count: active_lanes clamped to the table size
    localparam logic [wlp_pkg::CNT_W-1:0] LANES_MAX = wlp_pkg::CNT_W'(wlp_pkg::LANE_COUNT);
    logic [wlp_pkg::CNT_W-1:0] eff_lanes;
    assign eff_lanes = (r_active > LANES_MAX) ? LANES_MAX : r_active;

    // ------------------------------------------------------------------
    // Sequencer state and datapath registers
    // ------------------------------------------------------------------
    wlp_pkg::t_state                       r_state,    n_state;
    logic [wlp_pkg::LANE_W-1:0]            r_lane,     n_lane;     // walk position
    logic [wlp_pkg::LANE_W-1:0]            r_last,     n_last;     // last active lane
    logic [wlp_pkg::LANE_W-1:0]            r_best,     n_best;
    logic signed [wlp_pkg::CREDIT_W-1:0]   r_best_cr,  n_best_cr;
    logic [15:0]                           r_best_dep, n_best_dep;
    logic                                  r_found,    n_found;
    logic                                  r_fb,       n_fb;
    logic                                  r_none,     n_none;
    logic [wlp_pkg::TOTAL_W-1:0]           r_total,    n_total;
    wlp_pkg::t_req                         r_req,      n_req;
    logic                                  r_out_valid, n_out_valid;
    wlp_pkg::t_rsp                         r_rsp,      n_rsp;

    // Per-lane credits, one read/write address per cycle, apart from the clear of all lanes on a table write
    logic signed [wlp_pkg::CREDIT_W-1:0]   r_credit [wlp_pkg::LANE_COUNT];

    // Shared-unit operands
    logic [wlp_pkg::LANE_W-1:0]            rd_idx;
    logic signed [wlp_pkg::CREDIT_W-1:0]   cur_cr;
    logic [7:0]                            cur_w;
    logic [15:0]                           cur_dep;
    logic [15:0]                           depth_arr [wlp_pkg::LANE_COUNT];
    logic signed [wlp_pkg::ALU_W-1:0]      alu_op;
    logic signed [wlp_pkg::ALU_W-1:0]      alu_sum;
    logic signed [wlp_pkg::CREDIT_W-1:0]   alu_res;
    logic                                  cred_we;
    logic                                  hit;

    assign depth_arr[0] = r_req.depth_lane0;
    assign depth_arr[1] = r_req.depth_lane1;
    assign depth_arr[2] = r_req.depth_lane2;
    assign depth_arr[3] = r_req.depth_lane3;

    // Credit update walks the lanes; final debit targets the winner
    assign rd_idx  = (r_state == wlp_pkg::S_UPD) ? r_best : r_lane;
    assign cur_cr  = r_credit[rd_idx];
    assign cur_w   = r_weights[8*rd_idx +: 8];
    assign cur_dep = depth_arr[rd_idx];

    // Single saturating adder: +weight while raising, -total on debit
    assign alu_op  = (r_state == wlp_pkg::S_UPD)
                   ? -$signed(wlp_pkg::ALU_W'(r_total))
                   :  $signed(wlp_pkg::ALU_W'(cur_w));
    assign alu_sum = wlp_pkg::ALU_W'(cur_cr) + alu_op;
    assign alu_res = wlp_pkg::sat_credit(alu_sum);

    // Eligible and better than anything seen so far
    assign hit = (cur_dep < r_limit) && (!r_found || (cur_cr > r_best_cr));

    assign o_in_ready  = (r_state == wlp_pkg::S_IDLE);
    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_rsp;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= wlp_pkg::S_IDLE;
            r_out_valid <= 1'b0;
            for (int i = 0; i < wlp_pkg::LANE_COUNT; i++) begin
                r_credit[i] <= '0;
            end
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
            if (cred_clr) begin
                for (int i = 0; i < wlp_pkg::LANE_COUNT; i++) begin
                    r_credit[i] <= '0;
                end
            end else if (cred_we) begin
                r_credit[rd_idx] <= alu_res;
            end
        end
    end

    // Payload registers, no reset needed
    always_ff @(posedge i_clk) begin
        r_lane     <= n_lane;
        r_last     <= n_last;
        r_best     <= n_best;
        r_best_cr  <= n_best_cr;
        r_best_dep <= n_best_dep;
        r_found    <= n_found;
        r_fb       <= n_fb;
        r_none     <= n_none;
        r_total    <= n_total;
        r_req      <= n_req;
        r_rsp      <= n_rsp;
    end

    always_comb begin
        n_state     = r_state;
        n_lane      = r_lane;
        n_last      = r_last;
        n_best      = r_best;
        n_best_cr   = r_best_cr;
        n_best_dep  = r_best_dep;
        n_found     = r_found;
        n_fb        = r_fb;
        n_none      = r_none;
        n_total     = r_total;
        n_req       = r_req;
        n_rsp       = r_rsp;
        n_out_valid = r_out_valid;
        cred_we     = 1'b0;

        if (r_out_valid && i_out_ready) begin
            n_out_valid = 1'b0;
        end

        unique case (r_state)
            wlp_pkg::S_IDLE: begin
                if (i_in_valid) begin
                    n_req   = i_in_data;
                    n_lane  = '0;
                    n_total = '0;
                    n_found = 1'b0;
                    n_fb    = 1'b0;
                    n_best  = '0;
                    if (eff_lanes == '0) begin
                        // nothing to schedule, credits untouched
                        n_none  = 1'b1;
                        n_state = wlp_pkg::S_OUT;
                    end else begin
                        n_none  = 1'b0;
                        n_last  = wlp_pkg::LANE_W'(eff_lanes - 1'b1);
                        n_state = wlp_pkg::S_ADD;
                    end
                end
            end

            // raise each active credit by its weight, accumulate the total
            wlp_pkg::S_ADD: begin
                cred_we = 1'b1;
                n_total = r_total + wlp_pkg::TOTAL_W'(cur_w);
                if (r_lane == r_last) begin
                    n_lane  = '0;
                    n_state = wlp_pkg::S_PICK;
                end else begin
                    n_lane  = r_lane + 1'b1;
                end
            end

            // highest credit below the depth limit; strict > keeps lower lane
            wlp_pkg::S_PICK: begin
                if (hit) begin
                    n_best    = r_lane;
                    n_best_cr = cur_cr;
                    n_found   = 1'b1;
                end
                if (r_lane == r_last) begin
                    n_lane  = '0;
                    n_state = (r_found || hit) ? wlp_pkg::S_UPD : wlp_pkg::S_FALL;
                end else begin
                    n_lane  = r_lane + 1'b1;
                end
            end

            // every lane full: take the shallowest, lower lane on ties
            wlp_pkg::S_FALL: begin
                n_fb = 1'b1;
                if ((r_lane == '0) || (cur_dep < r_best_dep)) begin
                    n_best     = r_lane;
                    n_best_dep = cur_dep;
                end
                if (r_lane == r_last) begin
                    n_state = wlp_pkg::S_UPD;
                end else begin
                    n_lane  = r_lane + 1'b1;
                end
            end

            // debit the winner by the sum of weights
            wlp_pkg::S_UPD: begin
                cred_we = 1'b1;
                n_state = wlp_pkg::S_OUT;
            end

            // load the result register once it is free
            wlp_pkg::S_OUT: begin
                if (!r_out_valid || i_out_ready) begin
                    n_out_valid         = 1'b1;
                    n_rsp.chosen_id     = r_none ? 8'h00 : r_ids[8*r_best +: 8];
                    n_rsp.chosen_index  = r_none ? '0 : r_best;
                    n_rsp.used_fallback = r_fb;
                    n_rsp.no_lane       = r_none;
                    n_state             = wlp_pkg::S_IDLE;
                end
            end

            default: begin
                n_state = wlp_pkg::S_IDLE;
            end
        endcase
    end

`ifndef SYNTH
    // An empty lane table must report nothing chosen
    a_no_lane_clean: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_out_data.no_lane) |->
            (o_out_data.chosen_id == 8'h00 && o_out_data.chosen_index == '0 &&
             !o_out_data.used_fallback))
        else $error("no_lane result carries a lane");

    // The lane walk never runs past the last active lane
    a_walk_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == wlp_pkg::S_ADD || r_state == wlp_pkg::S_PICK ||
         r_state == wlp_pkg::S_FALL) |-> (r_lane <= r_last))
        else $error("lane walk out of range");

    // A new result only appears as the sequencer leaves its output step
    a_out_from_seq: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (!$past(r_out_valid) && r_out_valid) |-> ($past(r_state) == wlp_pkg::S_OUT))
        else $error("result loaded outside output step");
`endif

endmodule
